// ===== rtl/acfs_pkg.sv =====
// Package for the approach / collect / fire sequencer.
// Holds the beat payload types, the decoded item type, configuration types and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acfs_pkg;

	typedef enum logic [2:0] {
		ACT_TICK     = 3'd0,
		ACT_START    = 3'd1,
		ACT_ABORT    = 3'd2,
		ACT_COLLECT  = 3'd3,
		ACT_FORCE    = 3'd4,
		ACT_DISTANCE = 3'd5,
		ACT_ANGLE    = 3'd6
	} acfs_action_t;

	typedef enum logic [2:0] {
		CFG_ARRIVE_DISTANCE = 3'd0,
		CFG_APPROACH_SPEED  = 3'd1,
		CFG_APPROACH_TIMEOUT = 3'd2,
		CFG_DATA_TIMEOUT    = 3'd3,
		CFG_USE_DETECTION   = 3'd4,
		CFG_STEER_GAIN      = 3'd5,
		CFG_OMEGA_LIMIT     = 3'd6,
		CFG_FIRE_HOLD       = 3'd7
	} acfs_cfg_index_t;

	localparam logic [2:0] STATE_ABORTED = 3'd5;

	localparam logic [15:0] RST_ARRIVE_DISTANCE  = 16'd300;
	localparam logic [15:0] RST_APPROACH_SPEED   = 16'd150;
	localparam logic [15:0] RST_APPROACH_TIMEOUT = 16'd160;
	localparam logic [15:0] RST_DATA_TIMEOUT     = 16'd10;
	localparam logic        RST_USE_DETECTION    = 1'b1;
	localparam logic [15:0] RST_STEER_GAIN       = 16'd384;
	localparam logic [14:0] RST_OMEGA_LIMIT      = 15'd1000;
	localparam logic [15:0] RST_FIRE_HOLD        = 16'd20;

	typedef struct packed {
		logic [2:0]         action;
		logic [2:0]         target_state;
		logic signed [15:0] sample_value;
	} acfs_in_t;

	typedef struct packed {
		logic [2:0]         state_code;
		logic               auto_mode;
		logic               drive_valid;
		logic signed [15:0] linear_speed;
		logic signed [15:0] angular_rate;
		logic               fire_valid;
		logic               fire_level;
		logic               arrived_pulse;
	} acfs_out_t;

	typedef struct packed {
		logic        is_tick;
		logic        is_start;
		logic        is_abort;
		logic        is_collect;
		logic        is_force;
		logic        is_distance;
		logic        is_angle;
		logic [2:0]  target_state;
		logic [15:0] sample_value;
	} acfs_item_t;

	typedef struct packed {
		logic [15:0]        arrive_distance_mm;
		logic signed [15:0] approach_speed;
		logic [15:0]        approach_timeout_ticks;
		logic [15:0]        data_timeout_ticks;
		logic               use_detection;
		logic signed [15:0] steer_gain;
		logic [14:0]        omega_limit;
		logic [15:0]        fire_hold_ticks;
	} acfs_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/acfs_fifo.sv =====
// Two-entry queue of packed beats with registered storage.
// Generic; used between the front and back parts and on the result side.
`timescale 1ns / 1ps
`default_nettype none

module acfs_fifo #(
	parameter int Width = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [Width-1:0]      dout,
	output logic                  empty
);

	logic [Width-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push_en;
	logic             pop_en;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign push_en = push && !full;
	assign pop_en  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_en) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push_en} - {1'b0, pop_en};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/acfs_front.sv =====
// Front part: accepts input beats, classifies the action and queues decoded items.
// Depends on acfs_pkg and acfs_fifo.
`timescale 1ns / 1ps
`default_nettype none

module acfs_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire acfs_pkg::acfs_in_t   in_item,
	output logic                      full,
	input  wire logic                 take,
	output acfs_pkg::acfs_item_t      item,
	output logic                      item_empty
);

	acfs_pkg::acfs_item_t dec;
	logic [$bits(acfs_pkg::acfs_item_t)-1:0] q_dout;

	always_comb begin
		dec = '0;
		dec.target_state = in_item.target_state;
		dec.sample_value = in_item.sample_value;
		case (in_item.action)
			acfs_pkg::ACT_TICK:     dec.is_tick = 1'b1;
			acfs_pkg::ACT_START:    dec.is_start = 1'b1;
			acfs_pkg::ACT_ABORT:    dec.is_abort = 1'b1;
			acfs_pkg::ACT_COLLECT:  dec.is_collect = 1'b1;
			acfs_pkg::ACT_FORCE:    dec.is_force = (in_item.target_state <= acfs_pkg::STATE_ABORTED);
			acfs_pkg::ACT_DISTANCE: dec.is_distance = 1'b1;
			acfs_pkg::ACT_ANGLE:    dec.is_angle = 1'b1;
			default:                dec.is_tick = 1'b0;
		endcase
	end

	acfs_fifo #(
		.Width($bits(acfs_pkg::acfs_item_t))
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (dec),
		.full  (full),
		.pop   (take),
		.dout  (q_dout),
		.empty (item_empty)
	);

	assign item = acfs_pkg::acfs_item_t'(q_dout);

endmodule

`default_nettype wire

// ===== rtl/acfs_back.sv =====
// Back part: mission state, sample ageing, steering and the result queue.
// Depends on acfs_pkg and acfs_fifo.
`timescale 1ns / 1ps
`default_nettype none

module acfs_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire acfs_pkg::acfs_cfg_t  cfg,
	input  wire acfs_pkg::acfs_item_t item,
	input  wire logic                 item_empty,
	output logic                      take,
	output acfs_pkg::acfs_out_t       out_item,
	output logic                      empty,
	input  wire logic                 pop
);

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_APPROACH = 3'd1,
		ST_COLLECT  = 3'd2,
		ST_FIRE     = 3'd3,
		ST_DONE     = 3'd4,
		ST_ABORTED  = 3'd5
	} mode_t;

	mode_t       mode_q, n_mode, enter_st;
	logic [15:0] ticks_q, n_ticks;
	logic [15:0] dist_q, n_dist;
	logic [15:0] angle_q, n_angle;
	logic [15:0] dage_q, n_dage;
	logic [15:0] aage_q, n_aage;
	logic [15:0] fticks_q, n_fticks;
	logic        dseen_q, n_dseen;
	logic        aseen_q, n_aseen;
	logic        handed_q, n_handed;
	logic        cflag_q, n_cflag;
	logic        fstart_q, n_fstart;
	logic        enter_en;
	logic        forced;
	logic        out_full;
	logic [15:0] ft_cur;
	logic        fire_l;

	logic signed [31:0] prod;
	logic        [31:0] mag;
	logic        [23:0] rnd;
	logic        [14:0] rmag;
	logic signed [15:0] steer_rate;

	acfs_pkg::acfs_out_t res;
	logic [$bits(acfs_pkg::acfs_out_t)-1:0] out_dout;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	assign take = !item_empty && !out_full;

	always_comb begin
		prod = cfg.steer_gain * $signed(angle_q);
		mag  = prod[31] ? 32'(-prod) : 32'(prod);
		rnd  = 24'((mag + 32'd128) >> 8);
		rmag = (rnd > {9'd0, cfg.omega_limit}) ? cfg.omega_limit : rnd[14:0];
		steer_rate = prod[31] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
	end

	always_comb begin
		n_mode   = mode_q;
		n_ticks  = ticks_q;
		n_dist   = dist_q;
		n_angle  = angle_q;
		n_dage   = dage_q;
		n_aage   = aage_q;
		n_fticks = fticks_q;
		n_dseen  = dseen_q;
		n_aseen  = aseen_q;
		n_handed = handed_q;
		n_cflag  = cflag_q;
		n_fstart = fstart_q;
		enter_en = 1'b0;
		enter_st = ST_IDLE;
		forced   = 1'b0;
		ft_cur   = fstart_q ? fticks_q : 16'd0;
		fire_l   = (ft_cur < cfg.fire_hold_ticks);
		res      = '0;

		if (item.is_tick) begin
			n_ticks = sat_inc(ticks_q);
			n_dage  = sat_inc(dage_q);
			n_aage  = sat_inc(aage_q);
			case (mode_q)
				ST_APPROACH: begin
					res.drive_valid = 1'b1;
					if (n_ticks >= cfg.approach_timeout_ticks) begin
						enter_en = 1'b1;
						enter_st = ST_COLLECT;
					end else if (!cfg.use_detection) begin
						res.linear_speed = cfg.approach_speed;
					end else if (!(dseen_q && n_dage < cfg.data_timeout_ticks)) begin
						res.linear_speed = '0;
					end else if (dist_q[15] || dist_q <= cfg.arrive_distance_mm) begin
						enter_en = 1'b1;
						enter_st = ST_COLLECT;
					end else begin
						res.linear_speed = cfg.approach_speed;
						if (aseen_q && n_aage < cfg.data_timeout_ticks) begin
							res.angular_rate = steer_rate;
						end
					end
				end
				ST_COLLECT: begin
					if (!handed_q) begin
						res.drive_valid   = 1'b1;
						res.arrived_pulse = 1'b1;
						n_handed          = 1'b1;
					end
					if (cflag_q) begin
						enter_en = 1'b1;
						enter_st = ST_FIRE;
					end
				end
				ST_FIRE: begin
					n_fstart       = 1'b1;
					res.fire_valid = 1'b1;
					res.fire_level = fire_l;
					n_fticks       = sat_inc(ft_cur);
					if (!fire_l) begin
						enter_en = 1'b1;
						enter_st = ST_DONE;
					end
				end
				default: begin
					n_ticks = sat_inc(ticks_q);
				end
			endcase
		end
		if (item.is_start) begin
			if (mode_q == ST_IDLE || mode_q == ST_DONE || mode_q == ST_ABORTED) begin
				enter_en = 1'b1;
				enter_st = ST_APPROACH;
			end
		end
		if (item.is_abort) begin
			res.drive_valid = 1'b1;
			enter_en        = 1'b1;
			enter_st        = ST_ABORTED;
		end
		if (item.is_collect) begin
			n_cflag = 1'b1;
		end
		if (item.is_force) begin
			res.drive_valid = 1'b1;
			enter_en        = 1'b1;
			enter_st        = mode_t'(item.target_state);
			forced          = 1'b1;
		end
		if (item.is_distance) begin
			n_dist  = item.sample_value;
			n_dage  = '0;
			n_dseen = 1'b1;
		end
		if (item.is_angle) begin
			n_angle = item.sample_value;
			n_aage  = '0;
			n_aseen = 1'b1;
		end

		if (enter_en) begin
			n_mode   = enter_st;
			n_ticks  = '0;
			n_handed = 1'b0;
			n_fstart = 1'b0;
			if (enter_st == ST_COLLECT) begin
				n_cflag = 1'b0;
			end
		end

		res.state_code = n_mode;
		if (forced) begin
			res.auto_mode = (enter_st != ST_COLLECT);
		end else begin
			res.auto_mode = (n_mode == ST_APPROACH || n_mode == ST_FIRE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ST_IDLE;
			ticks_q  <= '0;
			dist_q   <= '0;
			angle_q  <= '0;
			dage_q   <= '0;
			aage_q   <= '0;
			fticks_q <= '0;
			dseen_q  <= 1'b0;
			aseen_q  <= 1'b0;
			handed_q <= 1'b0;
			cflag_q  <= 1'b0;
			fstart_q <= 1'b0;
		end else if (take) begin
			mode_q   <= n_mode;
			ticks_q  <= n_ticks;
			dist_q   <= n_dist;
			angle_q  <= n_angle;
			dage_q   <= n_dage;
			aage_q   <= n_aage;
			fticks_q <= n_fticks;
			dseen_q  <= n_dseen;
			aseen_q  <= n_aseen;
			handed_q <= n_handed;
			cflag_q  <= n_cflag;
			fstart_q <= n_fstart;
		end
	end

	acfs_fifo #(
		.Width($bits(acfs_pkg::acfs_out_t))
	) u_result_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.din   (res),
		.full  (out_full),
		.pop   (pop),
		.dout  (out_dout),
		.empty (empty)
	);

	assign out_item = acfs_pkg::acfs_out_t'(out_dout);

endmodule

`default_nettype wire

// ===== rtl/approach_collect_fire_sequencer_top.sv =====
// Top level of the approach / collect / fire mission sequencer.
// Depends on acfs_pkg, acfs_front and acfs_back; holds the configuration registers.
//
// Input beats (tick, start, abort, collect done, force state, distance or angle
// sample) are pushed while full is low; each returns exactly one result beat, in
// order, popped while empty is low. The block takes one beat per clock while the
// result queue is not full: the back part executes one decoded item per cycle, with
// the steering multiply, rounding and clamp done in that same cycle. Each result is
// registered into the result queue when the back part takes its item. Two-entry
// queues sit between the front and back parts and on the result side. Configuration
// writes are always ready and should be made only while no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module approach_collect_fire_sequencer_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire acfs_pkg::acfs_in_t in_item,
	output logic                    full,
	output acfs_pkg::acfs_out_t     out_item,
	output logic                    empty,
	input  wire logic               pop,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	acfs_pkg::acfs_cfg_t  cfg_q;
	acfs_pkg::acfs_item_t item;
	logic                 item_empty;
	logic                 take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arrive_distance_mm     <= acfs_pkg::RST_ARRIVE_DISTANCE;
			cfg_q.approach_speed         <= acfs_pkg::RST_APPROACH_SPEED;
			cfg_q.approach_timeout_ticks <= acfs_pkg::RST_APPROACH_TIMEOUT;
			cfg_q.data_timeout_ticks     <= acfs_pkg::RST_DATA_TIMEOUT;
			cfg_q.use_detection          <= acfs_pkg::RST_USE_DETECTION;
			cfg_q.steer_gain             <= acfs_pkg::RST_STEER_GAIN;
			cfg_q.omega_limit            <= acfs_pkg::RST_OMEGA_LIMIT;
			cfg_q.fire_hold_ticks        <= acfs_pkg::RST_FIRE_HOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				acfs_pkg::CFG_ARRIVE_DISTANCE:  cfg_q.arrive_distance_mm <= cfg_data;
				acfs_pkg::CFG_APPROACH_SPEED:   cfg_q.approach_speed <= cfg_data;
				acfs_pkg::CFG_APPROACH_TIMEOUT: cfg_q.approach_timeout_ticks <= cfg_data;
				acfs_pkg::CFG_DATA_TIMEOUT:     cfg_q.data_timeout_ticks <= cfg_data;
				acfs_pkg::CFG_USE_DETECTION:    cfg_q.use_detection <= cfg_data[0];
				acfs_pkg::CFG_STEER_GAIN:       cfg_q.steer_gain <= cfg_data;
				acfs_pkg::CFG_OMEGA_LIMIT:      cfg_q.omega_limit <= cfg_data[14:0];
				acfs_pkg::CFG_FIRE_HOLD:        cfg_q.fire_hold_ticks <= cfg_data;
				default:                        cfg_q.fire_hold_ticks <= cfg_q.fire_hold_ticks;
			endcase
		end
	end

	acfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_item   (in_item),
		.full      (full),
		.take      (take),
		.item      (item),
		.item_empty(item_empty)
	);

	acfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item),
		.item_empty(item_empty),
		.take      (take),
		.out_item  (out_item),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire
